FILE: design/etl_pkg.sv
`default_nettype none
package etl_pkg;

   // Position counter width.
   localparam int PosW = 16;
   localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

   // Tokens a single input byte can produce at most.
   localparam int MaxToks = 4;
   localparam int ToksW = $clog2(MaxToks);
   localparam int CntW = $clog2(MaxToks + 1);

   // Bundle queue depth.
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);
   localparam int QCntW = $clog2(QDepth + 1);

   // Token kinds.
   localparam logic [3:0] K_NUM = 4'd0;
   localparam logic [3:0] K_IDENT = 4'd1;
   localparam logic [3:0] K_OP = 4'd2;
   localparam logic [3:0] K_LPAR = 4'd3;
   localparam logic [3:0] K_RPAR = 4'd4;
   localparam logic [3:0] K_COMMA = 4'd5;
   localparam logic [3:0] K_END = 4'd6;
   localparam logic [3:0] K_BAD = 4'd7;
   localparam logic [3:0] K_LONG = 4'd8;

   // Scanner modes.
   localparam logic [3:0] M_IDLE = 4'd0;
   localparam logic [3:0] M_DOT = 4'd1;
   localparam logic [3:0] M_INT = 4'd2;
   localparam logic [3:0] M_FRAC = 4'd3;
   localparam logic [3:0] M_E = 4'd4;
   localparam logic [3:0] M_ESIGN = 4'd5;
   localparam logic [3:0] M_EXP = 4'd6;
   localparam logic [3:0] M_IDENT = 4'd7;
   localparam logic [3:0] M_ERR = 4'd8;

   // Characters.
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E = 8'h45;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_PCT = 8'h25;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LPAR = 8'h28;
   localparam logic [7:0] CH_RPAR = 8'h29;

   typedef struct packed {
      logic [3:0]      kind;
      logic [PosW-1:0] start_pos;
      logic [PosW-1:0] length;
      logic [7:0]      token_char;
   } tok_type;

   // All tokens caused by one input byte.
   typedef struct packed {
      logic [CntW-1:0]            count;
      tok_type [MaxToks-1:0]      toks;
   } bundle_type;

   function automatic tok_type make_tok(input logic [3:0] kind, input logic [PosW-1:0] start,
                                        input logic [PosW-1:0] len, input logic [7:0] tc);
      tok_type t;
      t.kind = kind;
      t.start_pos = start;
      t.length = len;
      t.token_char = tc;
      return t;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_letter(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
             (c == CH_CARET) || (c == CH_BANG) || (c == CH_PCT);
   endfunction

endpackage
`default_nettype wire

FILE: design/etl_front.sv
`default_nettype none
module etl_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_is_end,
   input  wire logic [7:0]          req_ch,
   input  wire logic                q_full,
   output logic                     push,
   output etl_pkg::bundle_type      push_data
);

   logic [3:0]                mode_ff, mode_in;
   logic [etl_pkg::PosW-1:0]  begin_ff, begin_in;
   logic [etl_pkg::PosW-1:0]  pos_ff, pos_in;
   logic                      sign_ff, sign_in;

   logic                      accept;
   logic                      do_start;
   logic [etl_pkg::CntW-1:0]  n;
   etl_pkg::tok_type [etl_pkg::MaxToks-1:0] toks;
   logic [etl_pkg::PosW-1:0]  p, pm1, pm2;
   logic [7:0]                sign_ch;

   assign accept = req_valid && !q_full;
   assign p = pos_ff;
   assign pm1 = pos_ff - etl_pkg::PosW'(1);
   assign pm2 = pos_ff - etl_pkg::PosW'(2);
   assign sign_ch = sign_ff ? etl_pkg::CH_MINUS : etl_pkg::CH_PLUS;

   always_comb begin
      mode_in = mode_ff;
      begin_in = begin_ff;
      pos_in = pos_ff;
      sign_in = sign_ff;
      do_start = 1'b0;
      n = '0;
      toks = '0;

      if (req_is_end) begin
         // flush whatever is open, then end
         case (mode_ff)
            etl_pkg::M_DOT: begin
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_BAD, begin_ff,
                                                 etl_pkg::PosW'(1), etl_pkg::CH_DOT);
               n = n + 1'b1;
            end
            etl_pkg::M_INT, etl_pkg::M_FRAC, etl_pkg::M_EXP: begin
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff,
                                                 p - begin_ff, 8'h00);
               n = n + 1'b1;
            end
            etl_pkg::M_E: begin
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff,
                                                 pm1 - begin_ff, 8'h00);
               n = n + 1'b1;
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_IDENT, pm1,
                                                 etl_pkg::PosW'(1), 8'h00);
               n = n + 1'b1;
            end
            etl_pkg::M_ESIGN: begin
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff,
                                                 pm2 - begin_ff, 8'h00);
               n = n + 1'b1;
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_IDENT, pm2,
                                                 etl_pkg::PosW'(1), 8'h00);
               n = n + 1'b1;
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_OP, pm1,
                                                 etl_pkg::PosW'(1), sign_ch);
               n = n + 1'b1;
            end
            etl_pkg::M_IDENT: begin
               toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_IDENT, begin_ff,
                                                 p - begin_ff, 8'h00);
               n = n + 1'b1;
            end
            default: begin
            end
         endcase
         toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_END, p, '0, 8'h00);
         n = n + 1'b1;
         mode_in = etl_pkg::M_IDLE;
         begin_in = '0;
         pos_in = '0;
         sign_in = 1'b0;
      end else if (mode_ff != etl_pkg::M_ERR) begin
         if (pos_ff == etl_pkg::PosMax) begin
            toks[0] = etl_pkg::make_tok(etl_pkg::K_LONG, p, '0, 8'h00);
            n = etl_pkg::CntW'(1);
            mode_in = etl_pkg::M_ERR;
         end else begin
            pos_in = pos_ff + etl_pkg::PosW'(1);
            case (mode_ff)
               etl_pkg::M_IDLE: do_start = 1'b1;
               etl_pkg::M_DOT: begin
                  if (etl_pkg::is_digit(req_ch)) begin
                     mode_in = etl_pkg::M_FRAC;
                  end else begin
                     toks[0] = etl_pkg::make_tok(etl_pkg::K_BAD, begin_ff,
                                                 etl_pkg::PosW'(1), etl_pkg::CH_DOT);
                     n = etl_pkg::CntW'(1);
                     mode_in = etl_pkg::M_ERR;
                  end
               end
               etl_pkg::M_INT, etl_pkg::M_FRAC: begin
                  if (etl_pkg::is_digit(req_ch)) begin
                     mode_in = mode_ff;
                  end else if ((mode_ff == etl_pkg::M_INT) && (req_ch == etl_pkg::CH_DOT)) begin
                     mode_in = etl_pkg::M_FRAC;
                  end else if ((req_ch == etl_pkg::CH_LOW_E) || (req_ch == etl_pkg::CH_UP_E)) begin
                     mode_in = etl_pkg::M_E;
                  end else begin
                     toks[0] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff, p - begin_ff, 8'h00);
                     n = etl_pkg::CntW'(1);
                     do_start = 1'b1;
                  end
               end
               etl_pkg::M_E: begin
                  if (etl_pkg::is_digit(req_ch)) begin
                     mode_in = etl_pkg::M_EXP;
                  end else if ((req_ch == etl_pkg::CH_PLUS) || (req_ch == etl_pkg::CH_MINUS)) begin
                     sign_in = (req_ch == etl_pkg::CH_MINUS);
                     mode_in = etl_pkg::M_ESIGN;
                  end else begin
                     // no exponent: the 'e' opens an identifier
                     toks[0] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff, pm1 - begin_ff, 8'h00);
                     n = etl_pkg::CntW'(1);
                     if (etl_pkg::is_word(req_ch)) begin
                        mode_in = etl_pkg::M_IDENT;
                        begin_in = pm1;
                     end else begin
                        toks[1] = etl_pkg::make_tok(etl_pkg::K_IDENT, pm1,
                                                    etl_pkg::PosW'(1), 8'h00);
                        n = etl_pkg::CntW'(2);
                        do_start = 1'b1;
                     end
                  end
               end
               etl_pkg::M_ESIGN: begin
                  if (etl_pkg::is_digit(req_ch)) begin
                     mode_in = etl_pkg::M_EXP;
                  end else begin
                     toks[0] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff, pm2 - begin_ff, 8'h00);
                     toks[1] = etl_pkg::make_tok(etl_pkg::K_IDENT, pm2,
                                                 etl_pkg::PosW'(1), 8'h00);
                     toks[2] = etl_pkg::make_tok(etl_pkg::K_OP, pm1,
                                                 etl_pkg::PosW'(1), sign_ch);
                     n = etl_pkg::CntW'(3);
                     do_start = 1'b1;
                  end
               end
               etl_pkg::M_EXP: begin
                  if (!etl_pkg::is_digit(req_ch)) begin
                     toks[0] = etl_pkg::make_tok(etl_pkg::K_NUM, begin_ff, p - begin_ff, 8'h00);
                     n = etl_pkg::CntW'(1);
                     do_start = 1'b1;
                  end
               end
               etl_pkg::M_IDENT: begin
                  if (!etl_pkg::is_word(req_ch)) begin
                     toks[0] = etl_pkg::make_tok(etl_pkg::K_IDENT, begin_ff, p - begin_ff, 8'h00);
                     n = etl_pkg::CntW'(1);
                     do_start = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            if (do_start) begin
               mode_in = etl_pkg::M_IDLE;
               if (etl_pkg::is_space(req_ch)) begin
                  mode_in = etl_pkg::M_IDLE;
               end else if (etl_pkg::is_digit(req_ch)) begin
                  mode_in = etl_pkg::M_INT;
                  begin_in = p;
               end else if (req_ch == etl_pkg::CH_DOT) begin
                  mode_in = etl_pkg::M_DOT;
                  begin_in = p;
               end else if (etl_pkg::is_letter(req_ch)) begin
                  mode_in = etl_pkg::M_IDENT;
                  begin_in = p;
               end else if (etl_pkg::is_op(req_ch)) begin
                  toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_OP, p,
                                                    etl_pkg::PosW'(1), req_ch);
                  n = n + 1'b1;
               end else if (req_ch == etl_pkg::CH_LPAR) begin
                  toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_LPAR, p,
                                                    etl_pkg::PosW'(1), 8'h00);
                  n = n + 1'b1;
               end else if (req_ch == etl_pkg::CH_RPAR) begin
                  toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_RPAR, p,
                                                    etl_pkg::PosW'(1), 8'h00);
                  n = n + 1'b1;
               end else if (req_ch == etl_pkg::CH_COMMA) begin
                  toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_COMMA, p,
                                                    etl_pkg::PosW'(1), 8'h00);
                  n = n + 1'b1;
               end else begin
                  toks[n[etl_pkg::ToksW-1:0]] = etl_pkg::make_tok(etl_pkg::K_BAD, p,
                                                    etl_pkg::PosW'(1), req_ch);
                  n = n + 1'b1;
                  mode_in = etl_pkg::M_ERR;
               end
            end
         end
      end
   end

   assign push = accept && (n != '0);
   assign push_data.count = n;
   assign push_data.toks = toks;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= etl_pkg::M_IDLE;
         begin_ff <= '0;
         pos_ff <= '0;
         sign_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         begin_ff <= begin_in;
         pos_ff <= pos_in;
         sign_ff <= sign_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/etl_queue.sv
`default_nettype none
module etl_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire etl_pkg::bundle_type  push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output etl_pkg::bundle_type       head
);

   etl_pkg::bundle_type             entry_ff [etl_pkg::QDepth];
   logic [etl_pkg::QPtrW-1:0]       wr_ff, wr_in;
   logic [etl_pkg::QPtrW-1:0]       rd_ff, rd_in;
   logic [etl_pkg::QCntW-1:0]       cnt_ff, cnt_in;

   assign full = (cnt_ff == etl_pkg::QCntW'(etl_pkg::QDepth));
   assign empty = (cnt_ff == '0);
   assign head = entry_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + etl_pkg::QCntW'(push) - etl_pkg::QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: design/etl_back.sv
`default_nettype none
module etl_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire etl_pkg::bundle_type  q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output etl_pkg::tok_type          rsp_tok,
   output logic                      rsp_last
);

   logic                       valid_ff, valid_in;
   etl_pkg::tok_type           tok_ff;
   logic                       last_ff;
   logic [etl_pkg::ToksW-1:0]  idx_ff, idx_in;
   logic                       load;
   logic                       at_last;

   assign load = !q_empty && (!valid_ff || !rsp_stall);
   assign at_last = ({1'b0, idx_ff} == (q_head.count - 1'b1));
   assign q_pop = load && at_last;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      idx_in = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= q_head.toks[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_tok = tok_ff;
   assign rsp_last = last_ff;

endmodule
`default_nettype wire

FILE: design/expression_token_lexer_core.sv
`default_nettype none
// Expression token lexer.
// Request channel (req_): one word per source byte, req_ch plus req_is_end;
// a word with req_is_end set closes the expression and carries no byte.
// Response channel (rsp_): one word per token: kind, start_pos, length,
// token_char, and rsp_last on the final token caused by one request word.
// A request word may cause zero tokens (blanks, bytes inside a token) or up
// to four (an end word closing a number with a dangling signed exponent).
// Throughput: one request word per cycle while req_stall is low, one token
// per cycle out while rsp_stall is low. The front end scans the byte
// combinationally and writes the whole token group into a four-deep group
// queue; the back end drains one token per cycle into the output register
// while rsp_stall is low. req_stall rises only when that queue is full,
// e.g. during long rsp_stall or a run of multi-token words.
// Reset (synchronous) empties the queue and output register and returns the
// scanner to idle at position zero. The receiver may hold rsp_stall for any
// time; rsp_ words then stay put and the queue absorbs the request side.
module expression_token_lexer_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_ch,
   input  wire logic         req_is_end,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [3:0]        rsp_kind,
   output logic [15:0]       rsp_start_pos,
   output logic [15:0]       rsp_length,
   output logic [7:0]        rsp_token_char,
   output logic              rsp_last
);

   logic                  q_full;
   logic                  q_empty;
   logic                  q_push;
   logic                  q_pop;
   etl_pkg::bundle_type   push_data;
   etl_pkg::bundle_type   q_head;
   etl_pkg::tok_type      out_tok;

   // scanner: state update and token group build
   etl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_end (req_is_end),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (push_data)
   );

   // decouples scanning from token drain
   etl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // serializer: one token per word onto rsp_
   etl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tok   (out_tok),
      .rsp_last  (rsp_last)
   );

   assign req_stall = q_full;

   assign rsp_kind = out_tok.kind;
   assign rsp_start_pos = 16'(out_tok.start_pos);
   assign rsp_length = 16'(out_tok.length);
   assign rsp_token_char = out_tok.token_char;

endmodule
`default_nettype wire

FILE: dv/expression_token_lexer_core_test.sv
`timescale 1ns / 100ps

module expression_token_lexer_core_test;

   // ---------------------------------------------------------------------
   // Clock, reset and the block's pins. Every input has a known value
   // from time zero; reset is held at the start of the run only.
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_ch = 8'h00;
   logic req_is_end = 1'b0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_kind;
   logic [15:0] rsp_start_pos;
   logic [15:0] rsp_length;
   logic [7:0] rsp_token_char;
   logic rsp_last;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   expression_token_lexer_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_is_end     (req_is_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_start_pos  (rsp_start_pos),
      .rsp_length     (rsp_length),
      .rsp_token_char (rsp_token_char),
      .rsp_last       (rsp_last)
   );

   // Cycles with no word moving on either side before the run is called hung.
   // The longest legal quiet stretch is a sender gap plus a receiver stall
   // block.
   localparam int IdleLimit = 1000;
   // Quiet cycles after the last token, to catch stray extra words.
   localparam int DrainCycles = 12;
   // Request words to send in all.
   localparam int NumWords = 360;

   localparam logic [7:0] DigitZero = 8'h30;
   localparam logic [7:0] LowerA = 8'h61;
   localparam logic [7:0] UpperA = 8'h41;

   typedef struct packed {
      etl_pkg::tok_type tok;
      logic             last;
   } expected_tok_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_BLOCKS, STALL_HEAVY}
      stall_style_type;

   // ---------------------------------------------------------------------
   // Token tracker: its own copy of the scanner state, the tokens that each
   // accepted request word must produce, and the check of every response
   // word against the oldest token still due.
   // ---------------------------------------------------------------------
   class lexer_tracker;
      logic [3:0]               mode;
      logic [etl_pkg::PosW-1:0] tok_begin;
      logic [etl_pkg::PosW-1:0] pos;
      logic                     neg_sign;
      etl_pkg::tok_type         group[$];
      expected_tok_type         tokens_due[$];
      int                       mismatches;
      int                       checked;
      int                       kind_seen[9];

      function new();
         restart();
      endfunction

      function void restart();
         mode = etl_pkg::M_IDLE;
         tok_begin = '0;
         pos = '0;
         neg_sign = 1'b0;
      endfunction

      function bit digit_ch(logic [7:0] c);
         return c >= DigitZero && c <= DigitZero + 8'd9;
      endfunction

      function bit letter_ch(logic [7:0] c);
         return (c >= LowerA && c <= LowerA + 8'd25) || (c >= UpperA && c <= UpperA + 8'd25);
      endfunction

      function bit word_ch(logic [7:0] c);
         return letter_ch(c) || digit_ch(c) || c == etl_pkg::CH_UNDER;
      endfunction

      function void add_tok(logic [3:0] kind, logic [etl_pkg::PosW-1:0] start,
                            logic [etl_pkg::PosW-1:0] len, logic [7:0] tc);
         etl_pkg::tok_type t;
         if (group.size() >= 5) return;
         t.kind = kind;
         t.start_pos = start;
         t.length = len;
         t.token_char = tc;
         group.insert(group.size(), t);
      endfunction

      // First byte with no token open.
      function void open_byte(logic [7:0] c, logic [etl_pkg::PosW-1:0] p);
         mode = etl_pkg::M_IDLE;
         if (c == etl_pkg::CH_SPACE || c == etl_pkg::CH_TAB || c == etl_pkg::CH_CR ||
             c == etl_pkg::CH_LF) return;
         if (digit_ch(c)) begin
            mode = etl_pkg::M_INT;
            tok_begin = p;
         end else if (c == etl_pkg::CH_DOT) begin
            mode = etl_pkg::M_DOT;
            tok_begin = p;
         end else if (letter_ch(c)) begin
            mode = etl_pkg::M_IDENT;
            tok_begin = p;
         end else if (c == etl_pkg::CH_PLUS || c == etl_pkg::CH_MINUS ||
                      c == etl_pkg::CH_STAR || c == etl_pkg::CH_SLASH ||
                      c == etl_pkg::CH_CARET || c == etl_pkg::CH_BANG ||
                      c == etl_pkg::CH_PCT) begin
            add_tok(etl_pkg::K_OP, p, etl_pkg::PosW'(1), c);
         end else if (c == etl_pkg::CH_LPAR) begin
            add_tok(etl_pkg::K_LPAR, p, etl_pkg::PosW'(1), 8'h00);
         end else if (c == etl_pkg::CH_RPAR) begin
            add_tok(etl_pkg::K_RPAR, p, etl_pkg::PosW'(1), 8'h00);
         end else if (c == etl_pkg::CH_COMMA) begin
            add_tok(etl_pkg::K_COMMA, p, etl_pkg::PosW'(1), 8'h00);
         end else begin
            add_tok(etl_pkg::K_BAD, p, etl_pkg::PosW'(1), c);
            mode = etl_pkg::M_ERR;
         end
      endfunction

      // The held 'e' (and sign) was not an exponent: close the number before
      // it, then the 'e' opens an identifier.
      function void split_exp(logic [etl_pkg::PosW-1:0] p, bit with_sign);
         logic [etl_pkg::PosW-1:0] epos;
         epos = p - (with_sign ? etl_pkg::PosW'(2) : etl_pkg::PosW'(1));
         add_tok(etl_pkg::K_NUM, tok_begin, epos - tok_begin, 8'h00);
         tok_begin = epos;
         mode = etl_pkg::M_IDENT;
         if (with_sign) begin
            add_tok(etl_pkg::K_IDENT, epos, etl_pkg::PosW'(1), 8'h00);
            add_tok(etl_pkg::K_OP, epos + 1'b1, etl_pkg::PosW'(1),
                    neg_sign ? etl_pkg::CH_MINUS : etl_pkg::CH_PLUS);
            mode = etl_pkg::M_IDLE;
         end
      endfunction

      function void scan_byte(logic [7:0] c, logic [etl_pkg::PosW-1:0] p, bit fin);
         case (mode)
            etl_pkg::M_DOT: begin
               if (!fin && digit_ch(c)) begin
                  mode = etl_pkg::M_FRAC;
                  return;
               end
               add_tok(etl_pkg::K_BAD, tok_begin, etl_pkg::PosW'(1), etl_pkg::CH_DOT);
               mode = etl_pkg::M_ERR;
               return;
            end
            etl_pkg::M_INT, etl_pkg::M_FRAC: begin
               if (!fin && digit_ch(c)) return;
               if (!fin && mode == etl_pkg::M_INT && c == etl_pkg::CH_DOT) begin
                  mode = etl_pkg::M_FRAC;
                  return;
               end
               if (!fin && (c == etl_pkg::CH_LOW_E || c == etl_pkg::CH_UP_E)) begin
                  mode = etl_pkg::M_E;
                  return;
               end
            end
            etl_pkg::M_E: begin
               if (!fin && digit_ch(c)) begin
                  mode = etl_pkg::M_EXP;
                  return;
               end
               if (!fin && (c == etl_pkg::CH_PLUS || c == etl_pkg::CH_MINUS)) begin
                  neg_sign = (c == etl_pkg::CH_MINUS);
                  mode = etl_pkg::M_ESIGN;
                  return;
               end
               // 'e' now heads an identifier; the byte continues it or ends it
               split_exp(p, 1'b0);
               if (!fin && word_ch(c)) return;
               add_tok(etl_pkg::K_IDENT, tok_begin, p - tok_begin, 8'h00);
               mode = etl_pkg::M_IDLE;
            end
            etl_pkg::M_ESIGN: begin
               if (!fin && digit_ch(c)) begin
                  mode = etl_pkg::M_EXP;
                  return;
               end
               split_exp(p, 1'b1);
            end
            etl_pkg::M_EXP: begin
               if (!fin && digit_ch(c)) return;
            end
            etl_pkg::M_IDENT: begin
               if (!fin && word_ch(c)) return;
               add_tok(etl_pkg::K_IDENT, tok_begin, p - tok_begin, 8'h00);
               mode = etl_pkg::M_IDLE;
            end
            etl_pkg::M_ERR: begin
               return;
            end
            default: begin
            end
         endcase
         if (mode == etl_pkg::M_INT || mode == etl_pkg::M_FRAC || mode == etl_pkg::M_EXP) begin
            add_tok(etl_pkg::K_NUM, tok_begin, p - tok_begin, 8'h00);
            mode = etl_pkg::M_IDLE;
         end
         if (!fin) open_byte(c, p);
      endfunction

      // Accepted request word. Returns 0 when the block just drops the byte.
      function bit note_word(logic [7:0] ch, logic is_end);
         bit scanned;
         expected_tok_type e;
         scanned = 1'b1;
         group.delete();
         if (is_end) begin
            scan_byte(8'h00, pos, 1'b1);
            add_tok(etl_pkg::K_END, pos, '0, 8'h00);
            restart();
         end else if (mode == etl_pkg::M_ERR) begin
            scanned = 1'b0;
         end else if (pos == etl_pkg::PosMax) begin
            add_tok(etl_pkg::K_LONG, pos, '0, 8'h00);
            mode = etl_pkg::M_ERR;
         end else begin
            scan_byte(ch, pos, 1'b0);
            pos = pos + 1'b1;
         end
         foreach (group[i]) begin
            e.tok = group[i];
            e.last = (i == group.size() - 1);
            tokens_due.insert(tokens_due.size(), e);
         end
         return scanned;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("mismatch %0d: %s", mismatches, msg);
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("token %0d %s: got 0x%0h, want 0x%0h",
                                      checked, name, got, want));
      endtask

      task check_token(logic [3:0] kind, logic [etl_pkg::PosW-1:0] start,
                       logic [etl_pkg::PosW-1:0] len, logic [7:0] tc, logic last);
         expected_tok_type want;
         if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("token kind %0d at %0d with none due", kind, start));
            return;
         end
         want = tokens_due.pop_front();
         checked++;
         if (want.tok.kind <= etl_pkg::K_LONG) kind_seen[want.tok.kind]++;
         compare_field("kind", 16'(kind), 16'(want.tok.kind));
         compare_field("start_pos", 16'(start), 16'(want.tok.start_pos));
         compare_field("length", 16'(len), 16'(want.tok.length));
         compare_field("token_char", 16'(tc), 16'(want.tok.token_char));
         compare_field("last", 16'(last), 16'(want.last));
      endtask
   endclass

   lexer_tracker sb = new();

   int  words_sent = 0;
   int  words_scanned = 0;
   int  burst_left = 0;
   int  idle_cycles = 0;

   // ---------------------------------------------------------------------
   // Response side. The receiver's stall follows a style that is picked
   // anew for each phase of random length: never, sparse, solid blocks,
   // or mostly stalled. Outputs are sampled at the falling edge, away from
   // any change, and a word seen there with stall low is taken at the next
   // rising edge.
   // ---------------------------------------------------------------------
   stall_style_type stall_style = STALL_NONE;
   int  stall_phase_left = 0;
   int  hold_left = 0;
   logic hold_level = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_phase_left = $urandom_range(50, 300);
         end
         stall_phase_left--;
         case (stall_style)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_SPARSE: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            STALL_BLOCKS: begin
               // alternating runs of stalled / free cycles of random length
               if (hold_left == 0) begin
                  hold_left = $urandom_range(1, 12);
                  hold_level = ~hold_level;
               end
               hold_left--;
               rsp_stall <= hold_level;
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_token(rsp_kind, rsp_start_pos, rsp_length, rsp_token_char, rsp_last);
   end

   // Hang detector: counts cycles where neither channel moves a word.
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: no word moved for %0d cycles, %0d tokens still due",
                  idle_cycles, sb.tokens_due.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side. Words go out in bursts of random length with random gaps
   // between them; some bursts are long, so there are stretches with no
   // sender idling at all.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [7:0] ch, input logic is_end);
      logic took;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_ch <= ch;
      req_is_end <= is_end;
      // stall is looked at mid-cycle; the word is taken at the next rising edge
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      words_sent++;
      if (sb.note_word(ch, is_end)) words_scanned++;
   endtask

   task automatic send_text(input string s, input bit close = 1'b1);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
      if (close) send_word(8'h00, 1'b1);
   endtask

   function automatic logic [7:0] any_digit();
      return DigitZero + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] any_letter();
      logic [7:0] r;
      r = 8'($urandom_range(0, 25));
      return $urandom_range(0, 1) ? LowerA + r : UpperA + r;
   endfunction

   function automatic logic [7:0] any_operator();
      case ($urandom_range(0, 6))
         0: return etl_pkg::CH_PLUS;
         1: return etl_pkg::CH_MINUS;
         2: return etl_pkg::CH_STAR;
         3: return etl_pkg::CH_SLASH;
         4: return etl_pkg::CH_CARET;
         5: return etl_pkg::CH_BANG;
         default: return etl_pkg::CH_PCT;
      endcase
   endfunction

   // One expression built from random pieces, mostly closed by an end word.
   // A broken one sprinkles in arbitrary bytes and bare dots, which usually
   // drive the scanner into its error mode part way through.
   task automatic send_random_expression(input bit broken);
      logic [7:0] text[$];
      int pieces;
      pieces = $urandom_range(1, 10);
      repeat (pieces) begin
         if (broken && $urandom_range(0, 4) == 0)
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         case ($urandom_range(0, 8))
            0, 1, 2: begin
               // integer, optional fraction, optional exponent (maybe dangling)
               repeat ($urandom_range(1, 3)) text.insert(text.size(), any_digit());
               if ($urandom_range(0, 1)) begin
                  text.insert(text.size(), etl_pkg::CH_DOT);
                  repeat ($urandom_range(0, 2)) text.insert(text.size(), any_digit());
               end
               if ($urandom_range(0, 1)) begin
                  text.insert(text.size(),
                              $urandom_range(0, 1) ? etl_pkg::CH_LOW_E : etl_pkg::CH_UP_E);
                  if ($urandom_range(0, 1))
                     text.insert(text.size(),
                                 $urandom_range(0, 1) ? etl_pkg::CH_MINUS : etl_pkg::CH_PLUS);
                  repeat ($urandom_range(0, 2)) text.insert(text.size(), any_digit());
               end
            end
            3: begin
               text.insert(text.size(), etl_pkg::CH_DOT);
               repeat ($urandom_range(broken ? 0 : 1, 2)) text.insert(text.size(), any_digit());
            end
            4: begin
               text.insert(text.size(), any_letter());
               repeat ($urandom_range(0, 5)) begin
                  case ($urandom_range(0, 3))
                     0: text.insert(text.size(), any_digit());
                     1: text.insert(text.size(), etl_pkg::CH_UNDER);
                     default: text.insert(text.size(), any_letter());
                  endcase
               end
            end
            5: text.insert(text.size(), any_operator());
            6: begin
               case ($urandom_range(0, 2))
                  0: text.insert(text.size(), etl_pkg::CH_LPAR);
                  1: text.insert(text.size(), etl_pkg::CH_RPAR);
                  default: text.insert(text.size(), etl_pkg::CH_COMMA);
               endcase
            end
            default: begin
               repeat ($urandom_range(1, 3)) begin
                  case ($urandom_range(0, 3))
                     0: text.insert(text.size(), etl_pkg::CH_SPACE);
                     1: text.insert(text.size(), etl_pkg::CH_TAB);
                     2: text.insert(text.size(), etl_pkg::CH_CR);
                     default: text.insert(text.size(), etl_pkg::CH_LF);
                  endcase
               end
            end
         endcase
      end
      foreach (text[i]) send_word(text[i], 1'b0);
      // the byte on an end word is junk and must be ignored
      if ($urandom_range(0, 9) != 0) send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: every token kind but too-long, every operator, signed and
      // unsigned exponents that fall apart, end flushing a held 'e', sign or
      // '.', a lone underscore, and bytes at both ends of the range.
      send_text("1.5e-3^(x_,.5)");
      send_text("2e+!");
      send_text("8E*/%");
      send_text("\t\r\n3e-");
      send_text("5e");
      send_text("a.");
      send_text("_\377k");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);

      // Random: mostly well-formed expressions, some broken ones, and
      // single words with random byte and end flag.
      while (words_sent < NumWords) begin
         case ($urandom_range(0, 19))
            0: send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            1, 2, 3: send_random_expression(1'b1);
            default: send_random_expression(1'b0);
         endcase
      end
      send_word(8'h00, 1'b1);
      req_valid <= 1'b0;

      while (sb.tokens_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d request words (%0d scanned) and %0d checked tokens",
               words_sent, words_scanned, sb.checked);
      $display("tokens: %0d number, %0d ident, %0d op, %0d end, %0d bad char, %0d too long",
               sb.kind_seen[etl_pkg::K_NUM], sb.kind_seen[etl_pkg::K_IDENT],
               sb.kind_seen[etl_pkg::K_OP], sb.kind_seen[etl_pkg::K_END],
               sb.kind_seen[etl_pkg::K_BAD], sb.kind_seen[etl_pkg::K_LONG]);
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/etl_pkg.sv
design/etl_front.sv
design/etl_queue.sv
design/etl_back.sv
design/expression_token_lexer_core.sv
dv/expression_token_lexer_core_test.sv
